// ===== rtl/bcp_pkg.sv =====
// Shared types, widths and the binomial table for the Bezier point evaluator.
`timescale 1ns / 1ps
package bcp_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int COORD_W    = 32;
    localparam int T_FRAC     = 16;
    localparam int T_W        = T_FRAC + 1;
    localparam int BIN_W      = 13;
    localparam int COEF_W     = COORD_W + BIN_W + 1;
    localparam int ACC_W      = 64;
    localparam int RND_W      = ACC_W - T_FRAC;

    localparam logic [T_W-1:0]   T_ONE  = T_W'(1) << T_FRAC;
    localparam logic [ACC_W-1:0] T_HALF = ACC_W'(1) << (T_FRAC - 1);

    typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BIN_W-1:0] bin_tab_t;

    // Build Pascal's triangle at elaboration; entries with k above n are zero
    function automatic bin_tab_t make_binoms();
        bin_tab_t tab;
        tab = '0;
        for (int n = 0; n < MAX_POINTS; n++) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (k == 0) begin
                    tab[n][k] = BIN_W'(1);
                end else if (n == 0) begin
                    tab[n][k] = '0;
                end else begin
                    tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
                end
            end
        end
        return tab;
    endfunction

    localparam bin_tab_t BINOM = make_binoms();

    // Commands from the sequencer to the power unit
    typedef struct packed {
        logic             init;
        logic             pow_en;
        logic             wgt_en;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] nk;
    } pwr_ctl_t;

endpackage

// ===== rtl/bezier_curve_point_eval.sv =====
// Top level of the Bezier curve point evaluator.
//
// Input channel s_*: one request per item. s_tuser selects load (0) or
// evaluate (1). A load stores control point point_index, scaled by the
// binomial of the current degree, in each lane's table and gives no
// result. An evaluate gives t and yields one point on m_*.
// Configuration: cfg_wr_en/cfg_wr_data set the degree (reset value 3);
// write it only while the block is idle.
// An evaluate runs an accept step, power steps in two 17x17 multipliers,
// weight steps with the three coordinate lanes' multiply-accumulate in
// parallel, a drain step and a merge step. The power chain and the one
// weight multiplier set the evaluation time.
// Reset clears the sequencer and output valid and sets the degree to 3; the
// coefficient tables are not cleared, so load every point before evaluating.
// If the receiver stalls, the result holds on m_*; the block still takes
// loads and the next evaluate, and waits in its merge cycle until the
// output register is free.
`timescale 1ns / 1ps
module bezier_curve_point_eval
    import bcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // point_index[3:0], x_in[35:4], y_in[67:36], z_in[99:68], t_param[116:100]
    input  logic [119:0]         s_tdata,
    // mode[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // x_out[31:0], y_out[63:32], z_out[95:64]
    output logic [3*COORD_W-1:0] m_tdata,
    // saturated[0]
    output logic                 m_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POW   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next, degree_reg;
    logic             accept, load_en, eval_go, slot_free, fin_load;
    pwr_ctl_t         ctl;
    logic [T_W-1:0]   weight;
    logic             weight_vld;
    logic [BIN_W-1:0] binom;
    logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

    logic [IDX_W-1:0]          in_idx;
    logic signed [COORD_W-1:0] in_x, in_y, in_z;
    logic [T_W-1:0]            in_t;

    // Unpack the request
    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_x   = s_tdata[4 +: COORD_W];
    assign in_y   = s_tdata[36 +: COORD_W];
    assign in_z   = s_tdata[68 +: COORD_W];
    assign in_t   = s_tdata[100 +: T_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_en  = accept && (s_tuser == MODE_LOAD);
    assign eval_go  = accept && (s_tuser == MODE_EVAL);
    assign binom    = BINOM[degree_reg][in_idx];
    assign fin_load = (state_reg == ST_FIN);

    // Hold the degree register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= IDX_W'(3);
        end else if (cfg_wr_en) begin
            degree_reg <= cfg_wr_data;
        end
    end

    // Sequence power steps, weight steps, drain and merge
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        ctl.init   = eval_go;
        ctl.pow_en = (state_reg == ST_POW);
        ctl.wgt_en = (state_reg == ST_SUM);
        ctl.k      = k_reg;
        ctl.nk     = degree_reg - k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (eval_go) begin
                    if (degree_reg == '0) begin
                        state_next = ST_SUM;
                        k_next     = '0;
                    end else begin
                        state_next = ST_POW;
                        k_next     = IDX_W'(1);
                    end
                end
            end
            ST_POW: begin
                if (k_reg == degree_reg) begin
                    state_next = ST_SUM;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_SUM: begin
                if (k_reg == degree_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    bcp_power u_power (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .t_param    (in_t),
        .weight     (weight),
        .weight_vld (weight_vld)
    );

    bcp_lane u_lane_x (
        .aclk (aclk), .load_en (load_en), .load_idx (in_idx), .coord (in_x),
        .binom (binom), .rd_en (ctl.wgt_en), .rd_idx (k_reg), .acc_clr (eval_go),
        .weight (weight), .weight_vld (weight_vld), .acc (acc_x)
    );

    bcp_lane u_lane_y (
        .aclk (aclk), .load_en (load_en), .load_idx (in_idx), .coord (in_y),
        .binom (binom), .rd_en (ctl.wgt_en), .rd_idx (k_reg), .acc_clr (eval_go),
        .weight (weight), .weight_vld (weight_vld), .acc (acc_y)
    );

    bcp_lane u_lane_z (
        .aclk (aclk), .load_en (load_en), .load_idx (in_idx), .coord (in_z),
        .binom (binom), .rd_en (ctl.wgt_en), .rd_idx (k_reg), .acc_clr (eval_go),
        .weight (weight), .weight_vld (weight_vld), .acc (acc_z)
    );

    bcp_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fin_load),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Power and weight steps never run past the degree
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POW || state_reg == ST_SUM) |-> (k_reg <= degree_reg))
        else $error("step index beyond degree");

    // An evaluate leaves idle, a load stays
    a_eval_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_go |=> (state_reg != ST_IDLE))
        else $error("evaluate did not start");

    // The merge waits while the output register is full
    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !slot_free) |=> (state_reg == ST_FIN))
        else $error("result overwritten");

    // Weights arrive only the cycle after a weight step
    a_wgt_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        weight_vld |-> $past(state_reg == ST_SUM))
        else $error("stray weight");

endmodule

// ===== rtl/bcp_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/bcp_power.sv =====
// Power sequence of t and 1-t and the weight t^k * (1-t)^(n-k) for each term.
`timescale 1ns / 1ps
module bcp_power
    import bcp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  pwr_ctl_t       ctl,
    input  logic [T_W-1:0] t_param,
    output logic [T_W-1:0] weight,
    output logic           weight_vld
);

    logic [T_W-1:0]   t_reg, u_reg, pt_run_reg, pu_run_reg;
    logic [T_W-1:0]   pt_arr_reg [MAX_POINTS];
    logic [T_W-1:0]   pu_arr_reg [MAX_POINTS];
    logic [T_W-1:0]   t_clip, pt_next, pu_next, w_next;
    logic [2*T_W-1:0] pt_prod, pu_prod, w_prod;
    logic [T_W-1:0]   w_reg;
    logic             w_vld_reg;

    // Clamp t to one
    assign t_clip = (t_param > T_ONE) ? T_ONE : t_param;

    // One rounded multiply per power and per weight
    assign pt_prod = pt_run_reg * t_reg + (2*T_W)'(T_HALF);
    assign pu_prod = pu_run_reg * u_reg + (2*T_W)'(T_HALF);
    assign w_prod  = pt_arr_reg[ctl.k] * pu_arr_reg[ctl.nk] + (2*T_W)'(T_HALF);
    assign pt_next = pt_prod[T_FRAC +: T_W];
    assign pu_next = pu_prod[T_FRAC +: T_W];
    assign w_next  = w_prod[T_FRAC +: T_W];

    // Advance the power chains
    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            t_reg         <= t_clip;
            u_reg         <= T_ONE - t_clip;
            pt_run_reg    <= T_ONE;
            pu_run_reg    <= T_ONE;
            pt_arr_reg[0] <= T_ONE;
            pu_arr_reg[0] <= T_ONE;
        end else if (ctl.pow_en) begin
            pt_run_reg        <= pt_next;
            pu_run_reg        <= pu_next;
            pt_arr_reg[ctl.k] <= pt_next;
            pu_arr_reg[ctl.k] <= pu_next;
        end
        if (ctl.wgt_en) begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_vld_reg <= 1'b0;
        end else begin
            w_vld_reg <= ctl.wgt_en;
        end
    end

    assign weight     = w_reg;
    assign weight_vld = w_vld_reg;

endmodule

// ===== rtl/bcp_lane.sv =====
// One coordinate lane: coefficient table and multiply-accumulate.
`timescale 1ns / 1ps
module bcp_lane
    import bcp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      load_en,
    input  logic [IDX_W-1:0]          load_idx,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [BIN_W-1:0]          binom,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_idx,
    input  logic                      acc_clr,
    input  logic [T_W-1:0]            weight,
    input  logic                      weight_vld,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [COEF_W-1:0] coef_wr, coef_rd;
    logic signed [ACC_W-1:0]  acc_reg, prod;

    // Scale the control point by its binomial on load
    assign coef_wr = COEF_W'($signed(coord) * $signed({1'b0, binom}));

    bcp_ram #(
        .WIDTH(COEF_W),
        .DEPTH(MAX_POINTS)
    ) u_coef (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (load_idx),
        .wr_data (coef_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_idx),
        .rd_data (coef_rd)
    );

    assign prod = ACC_W'($signed(coef_rd) * $signed({1'b0, weight}));

    // Accumulate one term per cycle
    always_ff @(posedge aclk) begin
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (weight_vld) begin
            acc_reg <= acc_reg + prod;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/bcp_merge.sv =====
// Round and saturate the three lane sums and hold the result request.
`timescale 1ns / 1ps
module bcp_merge
    import bcp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic signed [ACC_W-1:0] acc_x,
    input  logic signed [ACC_W-1:0] acc_y,
    input  logic signed [ACC_W-1:0] acc_z,
    output logic                    slot_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [3*COORD_W-1:0]    m_tdata,
    output logic                    m_tuser
);

    logic signed [ACC_W-1:0]   sum_x, sum_y, sum_z;
    logic signed [RND_W-1:0]   r_x, r_y, r_z;
    logic [COORD_W-1:0]        c_x, c_y, c_z;
    logic                      s_x, s_y, s_z;
    logic [3*COORD_W-1:0]      data_reg;
    logic                      sat_reg, vld_reg;

    localparam logic signed [RND_W-1:0] HI = RND_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [RND_W-1:0] LO = -HI - RND_W'(1);

    // Round half up by floor shift
    assign sum_x = acc_x + $signed(T_HALF);
    assign sum_y = acc_y + $signed(T_HALF);
    assign sum_z = acc_z + $signed(T_HALF);
    assign r_x   = RND_W'(sum_x >>> T_FRAC);
    assign r_y   = RND_W'(sum_y >>> T_FRAC);
    assign r_z   = RND_W'(sum_z >>> T_FRAC);

    // Clip to the coordinate range
    always_comb begin
        s_x = (r_x > HI) || (r_x < LO);
        s_y = (r_y > HI) || (r_y < LO);
        s_z = (r_z > HI) || (r_z < LO);
        c_x = (r_x > HI) ? HI[COORD_W-1:0] : (r_x < LO) ? LO[COORD_W-1:0] : r_x[COORD_W-1:0];
        c_y = (r_y > HI) ? HI[COORD_W-1:0] : (r_y < LO) ? LO[COORD_W-1:0] : r_y[COORD_W-1:0];
        c_z = (r_z > HI) ? HI[COORD_W-1:0] : (r_z < LO) ? LO[COORD_W-1:0] : r_z[COORD_W-1:0];
    end

    assign slot_free = !vld_reg || m_tready;

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (load && slot_free) begin
            data_reg <= {c_z, c_y, c_x};
            sat_reg  <= s_x | s_y | s_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (load && slot_free) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = sat_reg;

endmodule

// ===== test/bezier_curve_point_eval_tb.sv =====
// Self-checking testbench for the Bezier curve point evaluator.
`timescale 1ns / 1ps
module bezier_curve_point_eval_tb;
    import bcp_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               sat;
    } curve_pt_t;

    // Tracks the coefficient tables and predicts curve points
    class curve_scoreboard;
        longint cx[MAX_POINTS];
        longint cy[MAX_POINTS];
        longint cz[MAX_POINTS];
        int unsigned deg;
        curve_pt_t pending_pts[$];
        int errors;

        function void clear();
            deg = 3;
            errors = 0;
            for (int i = 0; i < MAX_POINTS; i++) begin
                cx[i] = 0;
                cy[i] = 0;
                cz[i] = 0;
            end
        endfunction

        function longint choose(int unsigned n, int unsigned k);
            longint c;
            c = 1;
            if (k > n) return 0;
            for (int unsigned i = 1; i <= k; i++) c = c * (n - i + 1) / i;
            return c;
        endfunction

        function logic [COORD_W-1:0] clip(longint s, inout logic sat);
            longint v;
            v = (s + 64'sd32768) >>> T_FRAC;
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647;
                sat = 1'b1;
            end
            if (v < -64'sd2147483648) begin
                v = -64'sd2147483648;
                sat = 1'b1;
            end
            return v[COORD_W-1:0];
        endfunction

        // Note one accepted request
        function void note_request(logic mode, logic [3:0] idx, logic [31:0] xi,
                                   logic [31:0] yi, logic [31:0] zi,
                                   logic [16:0] tp);
            longint unsigned pt[MAX_POINTS];
            longint unsigned pu[MAX_POINTS];
            longint unsigned t;
            longint unsigned u;
            longint w;
            longint sx;
            longint sy;
            longint sz;
            longint c;
            curve_pt_t r;
            if (!mode) begin
                c = choose(deg, idx);
                cx[idx] = longint'(signed'(xi)) * c;
                cy[idx] = longint'(signed'(yi)) * c;
                cz[idx] = longint'(signed'(zi)) * c;
                return;
            end
            t = (tp > 17'd65536) ? 65536 : tp;
            u = 65536 - t;
            pt[0] = 65536;
            pu[0] = 65536;
            for (int k = 1; k <= deg; k++) begin
                pt[k] = (pt[k-1] * t + 32768) >> T_FRAC;
                pu[k] = (pu[k-1] * u + 32768) >> T_FRAC;
            end
            sx = 0;
            sy = 0;
            sz = 0;
            for (int k = 0; k <= deg; k++) begin
                w = longint'((pt[k] * pu[deg-k] + 32768) >> T_FRAC);
                sx += cx[k] * w;
                sy += cy[k] * w;
                sz += cz[k] * w;
            end
            r.sat = 1'b0;
            r.x = clip(sx, r.sat);
            r.y = clip(sy, r.sat);
            r.z = clip(sz, r.sat);
            pending_pts.push_back(r);
        endfunction

        // Compare one result with the oldest expected point
        function void check_point(curve_pt_t got);
            curve_pt_t exp_pt;
            if (pending_pts.size() == 0) begin
                $display("%0t: unexpected point x=%h y=%h z=%h sat=%b", $realtime,
                         got.x, got.y, got.z, got.sat);
                errors++;
                return;
            end
            exp_pt = pending_pts.pop_front();
            if (got.x !== exp_pt.x) begin
                $display("%0t: x mismatch exp %h got %h", $realtime, exp_pt.x, got.x);
                errors++;
            end
            if (got.y !== exp_pt.y) begin
                $display("%0t: y mismatch exp %h got %h", $realtime, exp_pt.y, got.y);
                errors++;
            end
            if (got.z !== exp_pt.z) begin
                $display("%0t: z mismatch exp %h got %h", $realtime, exp_pt.z, got.z);
                errors++;
            end
            if (got.sat !== exp_pt.sat) begin
                $display("%0t: sat mismatch exp %b got %b", $realtime, exp_pt.sat,
                         got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [119:0]         s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [3*COORD_W-1:0] m_tdata;
    logic                 m_tuser;

    curve_scoreboard sb;
    int  hold_cycles;
    bit  max_pressure;

    bezier_curve_point_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Send one request and wait for its acceptance; valid stays up for a
    // back-to-back request and drops only before a gap
    task automatic send_request(logic mode, logic [3:0] idx, logic [31:0] xi,
                                logic [31:0] yi, logic [31:0] zi, logic [16:0] tp);
        int gap;
        gap = max_pressure ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, tp, zi, yi, xi, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, idx, xi, yi, zi, tp);
    endtask

    // Load every point of the current degree with random or extreme values
    task automatic load_curve(int kind);
        logic [31:0] v[3];
        for (int k = 0; k <= sb.deg; k++) begin
            for (int c = 0; c < 3; c++) begin
                case (kind)
                    0: v[c] = $urandom();
                    1: v[c] = 32'h7fffffff;
                    2: v[c] = 32'h80000000;
                    default: v[c] = $urandom_range(0, 32'h3ffff) - 32'h20000;
                endcase
            end
            send_request(1'b0, k[3:0], v[0], v[1], v[2], 17'($urandom()));
        end
    endtask

    task automatic evaluate(logic [16:0] tp);
        send_request(1'b1, 4'($urandom()), $urandom(), $urandom(), $urandom(), tp);
    endtask

    // Drop valid, wait until every point has come back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_pts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_degree(int unsigned d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= IDX_W'(d);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.deg = d;
    endtask

    // Receiver: random stalls, one long hold-off, check each point
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else begin
                gap = 0;
                if ($urandom_range(0, 3) != 0) gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                do @(posedge aclk); while (!m_tvalid);
                sb.check_point({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser});
            end
        end
    end

    initial begin
        int unsigned d;
        sb = new();
        sb.clear();
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        hold_cycles = 0;
        max_pressure = 1'b0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset degree, extreme points and t at both ends and above one
        load_curve(1);
        evaluate(17'd0);
        evaluate(17'd65536);
        evaluate(17'd32768);
        evaluate(17'h1ffff);
        load_curve(2);
        evaluate(17'd1);
        evaluate(17'd65535);
        drain();
        // Load at an index above the degree, which stores zero
        set_degree(1);
        load_curve(0);
        send_request(1'b0, 4'd15, 32'hffffffff, 32'h7fffffff, 32'h80000000, 17'd0);
        evaluate(17'd20000);
        drain();
        // Highest degree with maximal points, then degree zero with a single point
        set_degree(15);
        load_curve(1);
        evaluate(17'd32768);
        drain();
        set_degree(0);
        send_request(1'b0, 4'd0, 32'h12345678, 32'h80000000, 32'h7fffffff, 17'd0);
        evaluate(17'd40000);
        drain();

        // Random phases across degrees; loads within a phase may replace points
        for (int ph = 0; ph < 40; ph++) begin
            d = (ph % 8 == 0) ? 15 : (ph % 8 == 1) ? 1 : $urandom_range(1, 6);
            set_degree(d);
            load_curve($urandom_range(0, 3));
            if (ph == 5) begin
                max_pressure = 1'b1;
                hold_cycles = 600;
            end
            for (int i = 0; i < 40; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(1'b0, 4'($urandom_range(0, d)), $urandom(), $urandom(),
                                 $urandom(), 17'($urandom()));
                else if ($urandom_range(0, 9) == 0)
                    evaluate(17'($urandom()));
                else
                    evaluate(17'($urandom_range(0, 65536)));
            end
            max_pressure = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_pts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
